// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define VATF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VATF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VATF_ASSERT_NOW(lbl, ante, cons, msg)
`define VATF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/vatf_pkg.sv -----
// ----------------------------------------------------------------------------
// vatf_pkg
// codes, tables and conversion functions for the vertex attribute converter
// ----------------------------------------------------------------------------
package vatf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_ATTR_KIND    = 2'd0;
    localparam logic [1:0] CFG_ELEM_TYPE    = 2'd1;
    localparam logic [1:0] CFG_NORMALIZE_ON = 2'd2;
    localparam logic [1:0] CFG_COMP_COUNT   = 2'd3;

    // attribute kinds
    localparam logic [2:0] KIND_POSITION = 3'd0;
    localparam logic [2:0] KIND_TEXCOORD = 3'd1;
    localparam logic [2:0] KIND_NORMAL   = 3'd2;
    localparam logic [2:0] KIND_COLOUR   = 3'd3;
    localparam logic [2:0] KIND_WEIGHT   = 3'd4;
    localparam logic [2:0] KIND_BONE     = 3'd5;

    // element types
    localparam logic [2:0] ET_FLOAT  = 3'd0;
    localparam logic [2:0] ET_SBYTE  = 3'd1;
    localparam logic [2:0] ET_UBYTE  = 3'd2;
    localparam logic [2:0] ET_SSHORT = 3'd3;
    localparam logic [2:0] ET_USHORT = 3'd4;

    localparam logic [2:0] COMP_COUNT_RESET = 3'd4;
    localparam logic [2:0] COMP_MAX         = 3'd4;
    localparam logic [31:0] FP_ONE          = 32'h3F80_0000;

    typedef logic [31:0] ub_tbl_t [256];

    // unsigned byte over 255, rounded to nearest even, built at elaboration
    function automatic ub_tbl_t build_ub_tbl();
        ub_tbl_t t;
        int rem;
        int p;
        int cnt;
        logic started;
        logic qbit;
        logic [24:0] acc;
        logic [24:0] m;
        for (int v = 0; v < 256; v++) begin
            if (v == 0) begin
                t[v] = 32'd0;
            end else if (v == 255) begin
                t[v] = FP_ONE;
            end else begin
                rem = v;
                p = 0;
                cnt = 0;
                started = 1'b0;
                acc = '0;
                for (int i = 1; i <= 40; i++) begin
                    if (cnt < 25) begin
                        rem = rem * 2;
                        qbit = (rem >= 255);
                        if (qbit) rem = rem - 255;
                        if (!started && qbit) begin
                            started = 1'b1;
                            p = i;
                        end
                        if (started) begin
                            acc = {acc[23:0], qbit};
                            cnt = cnt + 1;
                        end
                    end
                end
                m = {1'b0, acc[24:1]};
                if (acc[0] && ((rem != 0) || acc[1])) m = m + 25'd1;
                t[v] = (32'(126 - p) << 23) + 32'(m);
            end
        end
        return t;
    endfunction

    localparam ub_tbl_t UB_NORM_TBL = build_ub_tbl();

    // lanes per kind
    function automatic logic [2:0] lanes_of_kind(logic [2:0] kind);
        logic [2:0] r;
        unique case (kind)
            KIND_POSITION: r = 3'd3;
            KIND_TEXCOORD: r = 3'd2;
            KIND_NORMAL:   r = 3'd3;
            KIND_COLOUR:   r = 3'd4;
            KIND_WEIGHT:   r = 3'd4;
            default:       r = 3'd0;
        endcase
        return r;
    endfunction

    // integer element to single, exact except the unsigned byte normalization
    function automatic logic [31:0] int_to_fp(logic [15:0] raw, logic [2:0] et,
                                              logic norm);
        logic        neg;
        logic [15:0] mag;
        logic [3:0]  pos;
        logic [4:0]  nsh;
        logic [7:0]  expo;
        logic [23:0] sig;
        logic [31:0] r;
        neg = 1'b0;
        mag = raw;
        nsh = 5'd0;
        unique case (et)
            ET_SBYTE:
            begin
                neg = raw[7];
                mag = {8'd0, raw[7] ? 8'(~raw[7:0] + 8'd1) : raw[7:0]};
                nsh = 5'd7;
            end
            ET_UBYTE:
            begin
                mag = {8'd0, raw[7:0]};
            end
            ET_SSHORT:
            begin
                neg = raw[15];
                mag = raw[15] ? 16'(~raw + 16'd1) : raw;
                nsh = 5'd15;
            end
            default:
            begin
                mag = raw;
                nsh = 5'd16;
            end
        endcase
        if (!norm) nsh = 5'd0;
        // leading one position
        pos = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) pos = 4'(i);
        end
        sig = 24'(mag) << (5'd23 - {1'b0, pos});
        expo = 8'(8'd127 + {4'd0, pos} - {3'd0, nsh});
        if (mag == 16'd0) r = 32'd0;
        else r = {neg, expo, sig[22:0]};
        if (norm && (et == ET_UBYTE)) r = UB_NORM_TBL[raw[7:0]];
        return r;
    endfunction

    // single over 512, rounded to nearest even with gradual underflow
    function automatic logic [31:0] div512(logic [31:0] x);
        logic [7:0]  e;
        logic [23:0] sig;
        logic [3:0]  sh;
        logic [33:0] ext;
        logic [24:0] q;
        logic [31:0] r;
        e = x[30:23];
        sig = {(e != 8'd0), x[22:0]};
        sh = (e == 8'd0) ? 4'd9 : 4'(8'd10 - e);
        ext = {sig, 10'd0} >> sh;
        q = {1'b0, ext[33:10]};
        if (ext[9] && ((|ext[8:0]) || ext[10])) q = q + 25'd1;
        if (e == 8'hFF) begin
            r = (x[22:0] != 23'd0) ? (x | 32'h0040_0000) : x;
        end else if (e > 8'd9) begin
            r = {x[31], 8'(e - 8'd9), x[22:0]};
        end else begin
            r = {x[31], 31'(q)};
        end
        return r;
    endfunction

    // truncate toward zero and clamp to 0..255, nan gives 0
    function automatic logic [7:0] to_index(logic [31:0] x);
        logic [7:0]  e;
        logic [23:0] sig;
        logic [23:0] iv;
        logic [7:0]  r;
        e = x[30:23];
        sig = {1'b1, x[22:0]};
        iv = sig >> 5'(8'd150 - e);
        if ((e == 8'hFF) && (x[22:0] != 23'd0)) r = 8'd0;
        else if (x[31] || (e < 8'd127)) r = 8'd0;
        else if (e >= 8'd135) r = 8'd255;
        else r = iv[7:0];
        return r;
    endfunction

endpackage

// ----- sv/vertex_attribute_to_float.sv -----
// ----------------------------------------------------------------------------
// vertex_attribute_to_float: input register, then result register
// throughput one request per cycle unless out_stall holds the result register, set by a single pass of lane conversion
// async active-low reset clears valids and config (comp_count resets to four)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_attribute_to_float
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    // input requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] raw_a,
    input  logic [31:0] raw_b,
    input  logic [31:0] raw_c,
    input  logic [31:0] raw_d,
    // result requests
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] val_a,
    output logic [31:0] val_b,
    output logic [31:0] val_c,
    output logic [31:0] val_d,
    output logic [31:0] index_word,
    output logic [2:0]  lanes_used,
    output logic        bad_type
);

    logic [2:0]  attr_kind_reg;
    logic [2:0]  elem_type_reg;
    logic        normalize_on_reg;
    logic [2:0]  comp_count_reg;

    logic        v1_reg;
    logic [31:0] raw_reg [4];
    logic        v2_reg;
    logic [31:0] val_reg [4];
    logic [31:0] word_reg;
    logic [2:0]  lanes_reg;
    logic        bad_reg;

    logic        s2_load;
    logic        s1_load;
    logic [31:0] val_next [4];
    logic [31:0] word_next;
    logic [2:0]  lanes_next;
    logic        bad_next;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_kind_reg    <= vatf_pkg::KIND_POSITION;
            elem_type_reg    <= vatf_pkg::ET_FLOAT;
            normalize_on_reg <= 1'b0;
            comp_count_reg   <= vatf_pkg::COMP_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vatf_pkg::CFG_ATTR_KIND:    attr_kind_reg    <= cfg_data;
                vatf_pkg::CFG_ELEM_TYPE:    elem_type_reg    <= cfg_data;
                vatf_pkg::CFG_NORMALIZE_ON: normalize_on_reg <= cfg_data[0];
                default:                    comp_count_reg   <= cfg_data;
            endcase
        end
    end

    // pipeline flow control
    assign s2_load  = v1_reg && (!v2_reg || !out_stall);
    assign s1_load  = !v1_reg || s2_load;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s1_load) v1_reg <= in_valid;
            if (s2_load) v2_reg <= 1'b1;
            else if (!out_stall) v2_reg <= 1'b0;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            raw_reg[0] <= raw_a;
            raw_reg[1] <= raw_b;
            raw_reg[2] <= raw_c;
            raw_reg[3] <= raw_d;
        end
    end

    // lane conversion and kind selection
    always_comb
    begin
        logic [2:0]  n;
        logic        bad;
        logic [31:0] rk;
        logic [31:0] bits [4];
        n = (comp_count_reg > vatf_pkg::COMP_MAX) ? vatf_pkg::COMP_MAX : comp_count_reg;
        bad = elem_type_reg > vatf_pkg::ET_USHORT;
        for (int k = 0; k < 4; k++)
        begin
            rk = (3'(k) < n) ? raw_reg[k] : 32'd0;
            if (elem_type_reg == vatf_pkg::ET_FLOAT) bits[k] = rk;
            else if (!bad) bits[k] = vatf_pkg::int_to_fp(rk[15:0], elem_type_reg,
                                                          normalize_on_reg);
            else bits[k] = 32'd0;
        end
        lanes_next = vatf_pkg::lanes_of_kind(attr_kind_reg);
        bad_next   = bad;
        word_next  = 32'd0;
        for (int k = 0; k < 4; k++) val_next[k] = 32'd0;
        if (!bad)
        begin
            priority if (attr_kind_reg == vatf_pkg::KIND_BONE)
            begin
                for (int k = 0; k < 4; k++)
                    word_next[8*k +: 8] = vatf_pkg::to_index(bits[k]);
            end
            else if (attr_kind_reg == vatf_pkg::KIND_TEXCOORD)
            begin
                for (int k = 0; k < 2; k++) val_next[k] = vatf_pkg::div512(bits[k]);
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                    if (3'(k) < lanes_next) val_next[k] = bits[k];
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            for (int k = 0; k < 4; k++) val_reg[k] <= val_next[k];
            word_reg  <= word_next;
            lanes_reg <= lanes_next;
            bad_reg   <= bad_next;
        end
    end

    assign out_valid  = v2_reg;
    assign val_a      = val_reg[0];
    assign val_b      = val_reg[1];
    assign val_c      = val_reg[2];
    assign val_d      = val_reg[3];
    assign index_word = word_reg;
    assign lanes_used = lanes_reg;
    assign bad_type   = bad_reg;

    // checks
    `VATF_ASSERT_NOW(a_bad_zero, out_valid && bad_type, (val_a == 32'd0) && (index_word == 32'd0), "bad type result not zero")
    `VATF_ASSERT_NOW(a_word_kind, out_valid && (index_word != 32'd0), lanes_used == 3'd0, "index word outside bone kind")
    `VATF_ASSERT_NOW(a_no_lanes, out_valid && (lanes_used == 3'd0), (val_a == 32'd0) && (val_d == 32'd0), "value in unused lane")
    `VATF_ASSERT_NEXT(a_take, in_valid && !in_stall, v1_reg, "accepted request not held")

endmodule
